// File: rtl/ghrb_pkg.sv
// ghrb_pkg: shared types, codes and small lookup functions for the
// gamepad report builder. no dependencies; imported by every rtl module.
package ghrb_pkg;

  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_BUTTON = 2'd2,
    OP_AXIS   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK       = 2'd0,
    STS_NO_SLOT  = 2'd1,
    STS_NO_PAD   = 2'd2,
    STS_BAD_CODE = 2'd3
  } status_t;

  localparam logic [3:0]  BTN_UNMAPPED = 4'd15;
  localparam logic [15:0] AXIS_CENTRE  = 16'h8000;
  localparam int          BTN_W        = 20;

  // command held for the whole transaction, broadcast to every cell
  typedef struct packed {
    op_t         op;
    logic [31:0] pad_id;
    logic [3:0]  button_code;
    logic        pressed;
    logic [2:0]  axis_code;
    logic [15:0] axis_value;
  } cmd_t;

  // slot contents as seen on the chain's result bus
  typedef struct packed {
    logic [BTN_W-1:0]  buttons;   // [15:0] report bits, [19:16] dpad u/d/l/r
    logic [3:0][15:0]  sticks;    // lx, ly, rx, ry
    logic [1:0][14:0]  triggers;  // left, right
  } slot_view_t;

  function automatic logic [BTN_W-1:0] button_bit(input logic [3:0] code);
    logic [BTN_W-1:0] b;
    case (code)
      4'd0:    b = 20'h00001;
      4'd1:    b = 20'h00002;
      4'd2:    b = 20'h00008;
      4'd3:    b = 20'h00010;
      4'd4:    b = 20'h00400;
      4'd5:    b = 20'h01000;
      4'd6:    b = 20'h00800;
      4'd7:    b = 20'h02000;
      4'd8:    b = 20'h04000;
      4'd9:    b = 20'h00040;
      4'd10:   b = 20'h00080;
      4'd11:   b = 20'h10000;
      4'd12:   b = 20'h20000;
      4'd13:   b = 20'h40000;
      4'd14:   b = 20'h80000;
      default: b = '0;
    endcase
    return b;
  endfunction

  // dpad bits: [0] up, [1] down, [2] left, [3] right
  function automatic logic [3:0] hat_code(input logic [3:0] dpad);
    logic [3:0] h;
    if (dpad[0]) begin
      h = dpad[2] ? 4'd8 : (dpad[3] ? 4'd2 : 4'd1);
    end else if (dpad[1]) begin
      h = dpad[2] ? 4'd6 : (dpad[3] ? 4'd4 : 4'd5);
    end else begin
      h = dpad[2] ? 4'd7 : (dpad[3] ? 4'd3 : 4'd0);
    end
    return h;
  endfunction

endpackage

// File: rtl/ghrb_cell.sv
// ghrb_cell: one gamepad slot of the chain, with its own search and update.
// depends on ghrb_pkg.
module ghrb_cell
  import ghrb_pkg::*;
#(
  parameter int            IW  = 3,
  parameter logic [IW-1:0] IDX = '0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  cmd_t          cmd,
  input  logic          look_en,
  input  logic          apply_en,
  input  logic          claim_in,
  output logic          claim_out,
  input  slot_view_t    view_in,
  output slot_view_t    view_out,
  input  logic [IW-1:0] idx_in,
  output logic [IW-1:0] idx_out
);

  logic             used_r, used_nxt;
  logic             grant_r;
  logic [31:0]      owner_r, owner_nxt;
  logic [BTN_W-1:0] btn_r, btn_nxt;
  logic [3:0][15:0] sticks_r, sticks_nxt;
  logic [1:0][14:0] trig_r, trig_nxt;
  logic             cand;
  logic [BTN_W-1:0] bit_sel;

  // candidate: free slot for an open, matching owner otherwise
  assign cand      = (cmd.op == OP_OPEN) ? !used_r : (used_r && owner_r == cmd.pad_id);
  assign claim_out = claim_in | cand;
  assign bit_sel   = button_bit(cmd.button_code);

  always_comb begin
    used_nxt   = used_r;
    owner_nxt  = owner_r;
    btn_nxt    = btn_r;
    sticks_nxt = sticks_r;
    trig_nxt   = trig_r;
    case (cmd.op)
      OP_OPEN: begin
        used_nxt   = 1'b1;
        owner_nxt  = cmd.pad_id;
        btn_nxt    = '0;
        sticks_nxt = {4{AXIS_CENTRE}};
        trig_nxt   = '0;
      end
      OP_CLOSE: begin
        used_nxt = 1'b0;
      end
      OP_BUTTON: begin
        btn_nxt = cmd.pressed ? (btn_r | bit_sel) : (btn_r & ~bit_sel);
      end
      OP_AXIS: begin
        if (!cmd.axis_code[2]) begin
          sticks_nxt[cmd.axis_code[1:0]] = cmd.axis_value ^ AXIS_CENTRE;
        end else if (!cmd.axis_code[1]) begin
          trig_nxt[cmd.axis_code[0]] = cmd.axis_value[15] ? 15'd0 : cmd.axis_value[14:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= 1'b0;
      grant_r <= 1'b0;
    end else begin
      if (look_en) begin
        grant_r <= cand & !claim_in;
      end
      if (apply_en && grant_r) begin
        used_r <= used_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (apply_en && grant_r) begin
      owner_r  <= owner_nxt;
      btn_r    <= btn_nxt;
      sticks_r <= sticks_nxt;
      trig_r   <= trig_nxt;
    end
  end

  // granted cell puts its updated contents on the result chain
  assign view_out = slot_view_t'(view_in | (grant_r ? {btn_nxt, sticks_nxt, trig_nxt} : '0));
  assign idx_out  = idx_in | (grant_r ? IDX : '0);

endmodule

// File: rtl/gamepad_hid_report_builder_core.sv
// gamepad_hid_report_builder_core: top level, slot chain plus sequencer and
// output register. depends on ghrb_pkg and ghrb_cell.
//
//  channel | handshake              | payload
//  --------+------------------------+---------------------------------------------
//  in_     | in_tvalid / in_tready  | tuser operation; tdata id, codes, value
//  out_    | out_tvalid / out_tready| tuser status, report_valid; tdata report
//  cfg_    | cfg_wr_en              | cfg_wr_data = first device id
//
// an item goes through a search state along the cell chain, then an update
// state for the slot update and loading of the output register. the next item
// is taken in the update cycle.
// the output register holds a result until taken; while it is full, the
// update cycle waits and takes no new item.
// reset clears the used bits of all slots at once, no clearing pass.
module gamepad_hid_report_builder_core
  import ghrb_pkg::*;
#(
  parameter int SLOT_COUNT = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [1:0]    in_tuser,    // [1:0] operation
  input  logic [55:0]   in_tdata,    // [31:0] pad_id, [35:32] button_code, [36] pressed,
                                     // [39:37] axis_code, [55:40] axis_value
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [2:0]    out_tuser,   // [1:0] status, [2] report_valid
  output logic [135:0]  out_tdata,   // [15:0] device_id, [31:16] left_x, [47:32] left_y,
                                     // [63:48] right_x, [79:64] right_y,
                                     // [94:80] left_trigger, [109:95] right_trigger,
                                     // [125:110] button_bits, [129:126] hat, rest zero
  input  logic          cfg_wr_en,
  input  logic [15:0]   cfg_wr_data  // first_device_id
);

  localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_APPLY
  } state_t;

  state_t       st_r;
  cmd_t         cmd_r, cmd_nxt;
  status_t      status_r, status_nxt;
  logic [15:0]  first_id_r;
  logic         out_tvalid_r;
  logic [2:0]   out_tuser_r;
  logic [135:0] out_tdata_r, out_tdata_nxt;

  logic         out_free;
  logic         look_en;
  logic         apply_en;
  logic         found;
  logic         report;
  logic [15:0]  dev_id;

  logic       [SLOT_COUNT:0] claim;
  slot_view_t                view [SLOT_COUNT+1];
  logic [IW-1:0]             idx  [SLOT_COUNT+1];

  assign out_free  = !out_tvalid_r || out_tready;
  assign in_tready = (st_r == S_IDLE) || (st_r == S_APPLY && out_free);
  assign look_en   = (st_r == S_LOOK);
  assign apply_en  = (st_r == S_APPLY) && out_free && (status_r == STS_OK);

  // unpack the incoming transaction
  always_comb begin
    cmd_nxt.op          = op_t'(in_tuser);
    cmd_nxt.pad_id      = in_tdata[31:0];
    cmd_nxt.button_code = in_tdata[35:32];
    cmd_nxt.pressed     = in_tdata[36];
    cmd_nxt.axis_code   = in_tdata[39:37];
    cmd_nxt.axis_value  = in_tdata[55:40];
  end

  // chain heads: nothing claimed, empty result bus
  assign claim[0] = 1'b0;
  assign view[0]  = '0;
  assign idx[0]   = '0;

  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cell
    ghrb_cell #(
      .IW  (IW),
      .IDX (IW'(g))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd_r),
      .look_en   (look_en),
      .apply_en  (apply_en),
      .claim_in  (claim[g]),
      .claim_out (claim[g+1]),
      .view_in   (view[g]),
      .view_out  (view[g+1]),
      .idx_in    (idx[g]),
      .idx_out   (idx[g+1])
    );
  end

  // chain end says whether any cell took the request
  assign found = claim[SLOT_COUNT];

  always_comb begin
    if (cmd_r.op == OP_OPEN) begin
      status_nxt = found ? STS_OK : STS_NO_SLOT;
    end else if (!found) begin
      status_nxt = STS_NO_PAD;
    end else if (cmd_r.op == OP_BUTTON && cmd_r.button_code == BTN_UNMAPPED) begin
      status_nxt = STS_BAD_CODE;
    end else if (cmd_r.op == OP_AXIS && cmd_r.axis_code[2] && cmd_r.axis_code[1]) begin
      status_nxt = STS_BAD_CODE;
    end else begin
      status_nxt = STS_OK;
    end
  end

  // button and axis events answer with a report; open and close do not
  assign report = (status_r == STS_OK) && (cmd_r.op == OP_BUTTON || cmd_r.op == OP_AXIS);
  assign dev_id = (status_r == STS_OK) ? 16'(first_id_r + 16'(idx[SLOT_COUNT])) : 16'd0;

  // result word, report fields zero unless a report goes out
  always_comb begin
    out_tdata_nxt       = '0;
    out_tdata_nxt[15:0] = dev_id;
    if (report) begin
      out_tdata_nxt[31:16]   = view[SLOT_COUNT].sticks[0];
      out_tdata_nxt[47:32]   = view[SLOT_COUNT].sticks[1];
      out_tdata_nxt[63:48]   = view[SLOT_COUNT].sticks[2];
      out_tdata_nxt[79:64]   = view[SLOT_COUNT].sticks[3];
      out_tdata_nxt[94:80]   = view[SLOT_COUNT].triggers[0];
      out_tdata_nxt[109:95]  = view[SLOT_COUNT].triggers[1];
      out_tdata_nxt[125:110] = view[SLOT_COUNT].buttons[15:0];
      out_tdata_nxt[129:126] = hat_code(view[SLOT_COUNT].buttons[19:16]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_tvalid_r <= 1'b0;
      first_id_r   <= '0;
    end else begin
      if (cfg_wr_en) begin
        first_id_r <= cfg_wr_data;
      end
      if (st_r == S_APPLY && out_free) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            st_r <= S_LOOK;
          end
        end
        S_LOOK: begin
          st_r <= S_APPLY;
        end
        S_APPLY: begin
          if (out_free) begin
            st_r <= in_tvalid ? S_LOOK : S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      cmd_r <= cmd_nxt;
    end
    if (st_r == S_LOOK) begin
      status_r <= status_nxt;
    end
    if (st_r == S_APPLY && out_free) begin
      out_tuser_r <= {report, status_r};
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_tuser_r;
  assign out_tdata  = out_tdata_r;

endmodule

// File: rtl/ghrb_checker.sv
// ghrb_checker: port-level assertions for the report builder, bound to the
// top level. depends on ghrb_pkg and the gamepad_hid_report_builder_core ports.
module ghrb_checker
  import ghrb_pkg::*;
(
  input logic         clk,
  input logic         rst_n,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [2:0]   out_tuser,
  input logic [135:0] out_tdata
);

  // a result held back keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // a report only comes with ok status and a hat code in range
  a_report_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == STS_OK && out_tdata[129:126] <= 4'd8)
    else $error("report with bad status or hat");

  // no report: report fields are zero
  a_no_report_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[135:16] == '0)
    else $error("report fields set without report");

  // failed request carries no device id
  a_fail_no_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1:0] != STS_OK |-> out_tdata[15:0] == 16'd0)
    else $error("device id on failed request");

  // nothing pending right after reset
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind gamepad_hid_report_builder_core ghrb_checker u_ghrb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

// File: test/testbench.sv
// testbench for gamepad_hid_report_builder_core: directed table plus random pad traffic, every
// result checked field by field against an in-bench slot table model or a typed row's answer.
// depends on ghrb_pkg and the rtl of the core.
module testbench;
  import ghrb_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int SLOTS = 8;

  // button codes on the input side
  localparam logic [3:0] BTN_SOUTH      = 4'd0;
  localparam logic [3:0] BTN_EAST       = 4'd1;
  localparam logic [3:0] BTN_WEST       = 4'd2;
  localparam logic [3:0] BTN_NORTH      = 4'd3;
  localparam logic [3:0] BTN_BACK       = 4'd4;
  localparam logic [3:0] BTN_GUIDE      = 4'd5;
  localparam logic [3:0] BTN_START      = 4'd6;
  localparam logic [3:0] BTN_LSTICK     = 4'd7;
  localparam logic [3:0] BTN_RSTICK     = 4'd8;
  localparam logic [3:0] BTN_LSHOULDER  = 4'd9;
  localparam logic [3:0] BTN_RSHOULDER  = 4'd10;
  localparam logic [3:0] BTN_DPAD_UP    = 4'd11;
  localparam logic [3:0] BTN_DPAD_DOWN  = 4'd12;
  localparam logic [3:0] BTN_DPAD_LEFT  = 4'd13;
  localparam logic [3:0] BTN_DPAD_RIGHT = 4'd14;

  // axis codes
  localparam logic [2:0] AXIS_LX     = 3'd0;
  localparam logic [2:0] AXIS_LY     = 3'd1;
  localparam logic [2:0] AXIS_RX     = 3'd2;
  localparam logic [2:0] AXIS_RY     = 3'd3;
  localparam logic [2:0] AXIS_LT     = 3'd4;
  localparam logic [2:0] AXIS_RT     = 3'd5;
  localparam logic [2:0] AXIS_BAD_LO = 3'd6;
  localparam logic [2:0] AXIS_BAD_HI = 3'd7;

  // d-pad bit positions inside a slot's key word
  localparam int DPAD_UP_BIT    = 16;
  localparam int DPAD_DOWN_BIT  = 17;
  localparam int DPAD_LEFT_BIT  = 18;
  localparam int DPAD_RIGHT_BIT = 19;

  // hat positions, clockwise from up
  localparam logic [3:0] HAT_CENTRE = 4'd0;
  localparam logic [3:0] HAT_N      = 4'd1;
  localparam logic [3:0] HAT_NE     = 4'd2;
  localparam logic [3:0] HAT_E      = 4'd3;
  localparam logic [3:0] HAT_SE     = 4'd4;
  localparam logic [3:0] HAT_S      = 4'd5;
  localparam logic [3:0] HAT_SW     = 4'd6;
  localparam logic [3:0] HAT_W      = 4'd7;
  localparam logic [3:0] HAT_NW     = 4'd8;

  typedef struct packed {
    op_t         op;
    logic [31:0] pad_id;
    logic [3:0]  bcode;
    logic        pressed;
    logic [2:0]  acode;
    logic [15:0] aval;
  } pad_event_t;

  typedef struct packed {
    status_t     status;
    logic        report_valid;
    logic [15:0] device_id;
    logic [15:0] left_x;
    logic [15:0] left_y;
    logic [15:0] right_x;
    logic [15:0] right_y;
    logic [14:0] left_trigger;
    logic [14:0] right_trigger;
    logic [15:0] button_bits;
    logic [3:0]  hat;
  } report_t;

  // one line of the directed table; typed rows carry their plain answer
  typedef struct packed {
    pad_event_t  ev;
    logic        typed;
    status_t     status;
    logic [15:0] device_id;
  } table_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;
  logic [55:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [2:0]   out_tuser;
  logic [135:0] out_tdata;
  logic         cfg_wr_en = 1'b0;
  logic [15:0]  cfg_wr_data = '0;

  // shadow slot table
  logic        pad_used   [SLOTS];
  logic [31:0] pad_owner  [SLOTS];
  logic [19:0] pad_keys   [SLOTS];
  logic [15:0] pad_sticks [SLOTS][4];
  logic [14:0] pad_trig   [SLOTS][2];
  logic [15:0] base_device_id = '0;

  report_t    expected_reports [$];
  table_row_t directed_rows [$];
  int         mismatch_count = 0;
  int         reports_seen = 0;
  bit         quiet = 1'b0;
  int         stall_left = 0;

  gamepad_hid_report_builder_core #(
    .SLOT_COUNT (SLOTS)
  ) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tuser   (out_tuser),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // generous cap, far beyond the slowest legal run
  initial begin
    #(2_000_000);
    $display("FAILURE");
    $finish;
  end

  // key word bit for each button code, zero when unmapped
  function automatic logic [19:0] key_mask(logic [3:0] code);
    logic [19:0] m;
    case (code)
      BTN_SOUTH:      m = 20'h00001;
      BTN_EAST:       m = 20'h00002;
      BTN_WEST:       m = 20'h00008;
      BTN_NORTH:      m = 20'h00010;
      BTN_BACK:       m = 20'h00400;
      BTN_GUIDE:      m = 20'h01000;
      BTN_START:      m = 20'h00800;
      BTN_LSTICK:     m = 20'h02000;
      BTN_RSTICK:     m = 20'h04000;
      BTN_LSHOULDER:  m = 20'h00040;
      BTN_RSHOULDER:  m = 20'h00080;
      BTN_DPAD_UP:    m = 20'h1 << DPAD_UP_BIT;
      BTN_DPAD_DOWN:  m = 20'h1 << DPAD_DOWN_BIT;
      BTN_DPAD_LEFT:  m = 20'h1 << DPAD_LEFT_BIT;
      BTN_DPAD_RIGHT: m = 20'h1 << DPAD_RIGHT_BIT;
      default:        m = '0;
    endcase
    return m;
  endfunction

  // up beats down, left beats right
  function automatic logic [3:0] hat_position(logic [19:0] keys);
    int vert;
    int horz;
    vert = keys[DPAD_UP_BIT] ? -1 : (keys[DPAD_DOWN_BIT] ? 1 : 0);
    horz = keys[DPAD_LEFT_BIT] ? -1 : (keys[DPAD_RIGHT_BIT] ? 1 : 0);
    if (vert < 0) return (horz < 0) ? HAT_NW : ((horz > 0) ? HAT_NE : HAT_N);
    if (vert > 0) return (horz < 0) ? HAT_SW : ((horz > 0) ? HAT_SE : HAT_S);
    return (horz < 0) ? HAT_W : ((horz > 0) ? HAT_E : HAT_CENTRE);
  endfunction

  function automatic logic [15:0] slot_device(int s);
    return base_device_id + 16'(s);
  endfunction

  function automatic report_t full_report(int s);
    report_t r;
    r = '0;
    r.status        = STS_OK;
    r.report_valid  = 1'b1;
    r.device_id     = slot_device(s);
    r.left_x        = pad_sticks[s][0];
    r.left_y        = pad_sticks[s][1];
    r.right_x       = pad_sticks[s][2];
    r.right_y       = pad_sticks[s][3];
    r.left_trigger  = pad_trig[s][0];
    r.right_trigger = pad_trig[s][1];
    r.button_bits   = pad_keys[s][15:0];
    r.hat           = hat_position(pad_keys[s]);
    return r;
  endfunction

  // updates the shadow table for one event and returns the report it causes
  function automatic report_t apply_pad_event(pad_event_t ev);
    report_t     r;
    int          s;
    logic [19:0] m;
    r = '0;
    s = -1;
    if (ev.op == OP_OPEN) begin
      for (int k = 0; k < SLOTS && s < 0; k++)
        if (!pad_used[k]) s = k;
      if (s < 0) begin
        r.status = STS_NO_SLOT;
      end else begin
        pad_used[s]  = 1'b1;
        pad_owner[s] = ev.pad_id;
        pad_keys[s]  = '0;
        for (int a = 0; a < 4; a++) pad_sticks[s][a] = AXIS_CENTRE;
        pad_trig[s][0] = '0;
        pad_trig[s][1] = '0;
        r.device_id = slot_device(s);
      end
      return r;
    end
    // lowest used slot owned by this id
    for (int k = 0; k < SLOTS && s < 0; k++)
      if (pad_used[k] && pad_owner[k] == ev.pad_id) s = k;
    if (s < 0) begin
      r.status = STS_NO_PAD;
    end else if (ev.op == OP_CLOSE) begin
      pad_used[s] = 1'b0;
      r.device_id = slot_device(s);
    end else if (ev.op == OP_BUTTON) begin
      m = key_mask(ev.bcode);
      if (ev.bcode == BTN_UNMAPPED || m == '0) begin
        r.status = STS_BAD_CODE;
      end else begin
        pad_keys[s] = ev.pressed ? (pad_keys[s] | m) : (pad_keys[s] & ~m);
        r = full_report(s);
      end
    end else if (ev.acode <= AXIS_RY) begin
      // sticks go to offset binary
      pad_sticks[s][ev.acode] = ev.aval ^ AXIS_CENTRE;
      r = full_report(s);
    end else if (ev.acode <= AXIS_RT) begin
      // negative trigger levels clamp to zero
      pad_trig[s][ev.acode - AXIS_LT] = ev.aval[15] ? 15'd0 : ev.aval[14:0];
      r = full_report(s);
    end else begin
      r.status = STS_BAD_CODE;
    end
    return r;
  endfunction

  function automatic logic [15:0] axis_sample();
    if ($urandom_range(0, 7) != 0) return 16'($urandom);
    case ($urandom_range(0, 3))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      default: return 16'hFFFF;
    endcase
  endfunction

  // mostly well-formed traffic on live pads, with opens and closes keeping the
  // table churning and a little noise on unknown ids and bad codes
  function automatic pad_event_t random_event();
    pad_event_t ev;
    int         live [$];
    int         roll;
    int         open_cut;
    logic [31:0] live_id;
    for (int k = 0; k < SLOTS; k++)
      if (pad_used[k]) live.push_back(k);
    ev.op      = OP_BUTTON;
    ev.pad_id  = $urandom;
    ev.bcode   = 4'($urandom_range(0, 14));
    ev.pressed = 1'($urandom_range(0, 1));
    ev.acode   = 3'($urandom_range(0, 5));
    ev.aval    = axis_sample();
    live_id    = (live.size() != 0) ? pad_owner[live[$urandom_range(0, live.size() - 1)]] : '0;
    roll       = $urandom_range(0, 99);
    open_cut   = 4 + 3 + 2 * (SLOTS - live.size());
    if (roll < 4) begin
      ev.op    = op_t'($urandom_range(0, 3));
      ev.bcode = 4'($urandom_range(0, 15));
      ev.acode = 3'($urandom_range(0, 7));
    end else if (live.size() == 0 || roll < open_cut) begin
      ev.op = OP_OPEN;
      // some opens reuse an id that already owns a slot
      if (live.size() != 0 && $urandom_range(0, 4) == 0) ev.pad_id = live_id;
    end else if (roll < open_cut + 8) begin
      ev.op     = OP_CLOSE;
      ev.pad_id = live_id;
    end else if (roll < 68) begin
      ev.op     = OP_BUTTON;
      ev.pad_id = live_id;
      if ($urandom_range(0, 15) == 0) ev.bcode = BTN_UNMAPPED;
    end else begin
      ev.op     = OP_AXIS;
      ev.pad_id = live_id;
      if ($urandom_range(0, 7) == 0) ev.acode = 3'($urandom_range(AXIS_BAD_LO, AXIS_BAD_HI));
    end
    return ev;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch in report %0d: %s got %h expected %h", reports_seen, what, got, want);
    mismatch_count++;
  endtask

  // one transaction on the input channel, then maybe a short idle burst
  task automatic send_event(pad_event_t ev, bit use_typed, report_t typed);
    report_t predicted;
    in_tvalid <= 1'b1;
    in_tuser  <= ev.op;
    in_tdata  <= {ev.aval, ev.acode, ev.pressed, ev.bcode, ev.pad_id};
    do @(posedge clk); while (!in_tready);
    predicted = apply_pad_event(ev);
    expected_reports.push_back(use_typed ? typed : predicted);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // block goes quiet: every report taken and the pipeline given time to empty
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_first_id(logic [15:0] value);
    drain_block();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    base_device_id = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic random_phase(int count, bit pause_midway);
    for (int k = 0; k < count; k++) begin
      if (pause_midway && k == count / 2) drain_block();
      send_event(random_event(), 1'b0, '0);
    end
  endtask

  function automatic void add_row(op_t op, logic [31:0] id, logic [3:0] bcode, logic pressed,
                                  logic [2:0] acode, logic [15:0] aval, logic typed,
                                  status_t status, logic [15:0] dev);
    table_row_t row;
    row.ev        = '{op, id, bcode, pressed, acode, aval};
    row.typed     = typed;
    row.status    = status;
    row.device_id = dev;
    directed_rows.push_back(row);
  endfunction

  // receiver: ready drops at random, in bursts, except in the quiet tail
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && rst_n && $urandom_range(0, 5) == 0) begin
      out_tready <= 1'b0;
      stall_left <= $urandom_range(0, 3);
    end else begin
      out_tready <= 1'b1;
    end
  end

  // result checker: oldest expectation first
  always @(posedge clk) begin
    report_t got;
    report_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status        = status_t'(out_tuser[1:0]);
      got.report_valid  = out_tuser[2];
      got.device_id     = out_tdata[15:0];
      got.left_x        = out_tdata[31:16];
      got.left_y        = out_tdata[47:32];
      got.right_x       = out_tdata[63:48];
      got.right_y       = out_tdata[79:64];
      got.left_trigger  = out_tdata[94:80];
      got.right_trigger = out_tdata[109:95];
      got.button_bits   = out_tdata[125:110];
      got.hat           = out_tdata[129:126];
      if (expected_reports.size() == 0) begin
        report_mismatch("unexpected report, tdata low word", out_tdata[31:0], '0);
      end else begin
        want = expected_reports.pop_front();
        if (got.status !== want.status) report_mismatch("status", got.status, want.status);
        if (got.report_valid !== want.report_valid)
          report_mismatch("report_valid", got.report_valid, want.report_valid);
        if (got.device_id !== want.device_id)
          report_mismatch("device_id", got.device_id, want.device_id);
        if (got.left_x !== want.left_x) report_mismatch("left_x", got.left_x, want.left_x);
        if (got.left_y !== want.left_y) report_mismatch("left_y", got.left_y, want.left_y);
        if (got.right_x !== want.right_x) report_mismatch("right_x", got.right_x, want.right_x);
        if (got.right_y !== want.right_y) report_mismatch("right_y", got.right_y, want.right_y);
        if (got.left_trigger !== want.left_trigger)
          report_mismatch("left_trigger", got.left_trigger, want.left_trigger);
        if (got.right_trigger !== want.right_trigger)
          report_mismatch("right_trigger", got.right_trigger, want.right_trigger);
        if (got.button_bits !== want.button_bits)
          report_mismatch("button_bits", got.button_bits, want.button_bits);
        if (got.hat !== want.hat) report_mismatch("hat", got.hat, want.hat);
      end
      reports_seen++;
    end
  end

  initial begin
    report_t typed;
    for (int k = 0; k < SLOTS; k++) pad_used[k] = 1'b0;

    // directed table, first device id still at its reset value of zero
    // unknown pad, also when the code is bad too
    add_row(OP_BUTTON, 32'h12345678, BTN_SOUTH, 1'b1, AXIS_LX, 16'h0000, 1'b1, STS_NO_PAD, 16'd0);
    add_row(OP_AXIS, 32'h12345678, BTN_SOUTH, 1'b0, AXIS_BAD_HI, 16'h0000, 1'b1, STS_NO_PAD, 16'd0);
    // opens at the id extremes, then a duplicate open
    add_row(OP_OPEN, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1, STS_OK, 16'd0);
    add_row(OP_OPEN, 32'hFFFFFFFF, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1, STS_OK, 16'd1);
    add_row(OP_OPEN, 32'hFFFFFFFF, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1, STS_OK, 16'd2);
    // known pad with a bad code
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_UNMAPPED, 1'b1, AXIS_LX, 16'h0000, 1'b1,
            STS_BAD_CODE, 16'd0);
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_BAD_LO, 16'h0000, 1'b1,
            STS_BAD_CODE, 16'd0);
    // axis extremes, trigger clamp on negative values
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_LX, 16'h8000, 1'b0, STS_OK, 16'd0);
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_LY, 16'h7FFF, 1'b0, STS_OK, 16'd0);
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_RX, 16'h0000, 1'b0, STS_OK, 16'd0);
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_RY, 16'hFFFF, 1'b0, STS_OK, 16'd0);
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_LT, 16'h7FFF, 1'b0, STS_OK, 16'd0);
    add_row(OP_AXIS, 32'h00000000, BTN_SOUTH, 1'b0, AXIS_RT, 16'h8000, 1'b0, STS_OK, 16'd0);
    // d-pad with opposite directions held together
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_DPAD_UP, 1'b1, AXIS_LX, 16'h0000, 1'b0, STS_OK, 16'd0);
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_DPAD_LEFT, 1'b1, AXIS_LX, 16'h0000, 1'b0, STS_OK, 16'd0);
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_DPAD_DOWN, 1'b1, AXIS_LX, 16'h0000, 1'b0, STS_OK, 16'd0);
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_DPAD_RIGHT, 1'b1, AXIS_LX, 16'h0000, 1'b0,
            STS_OK, 16'd0);
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_DPAD_UP, 1'b0, AXIS_LX, 16'h0000, 1'b0, STS_OK, 16'd0);
    // close the first of the duplicate slots, the second one still answers
    add_row(OP_CLOSE, 32'hFFFFFFFF, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1, STS_OK, 16'd1);
    add_row(OP_BUTTON, 32'hFFFFFFFF, BTN_RSHOULDER, 1'b1, AXIS_LX, 16'h0000, 1'b0,
            STS_OK, 16'd0);
    // reopen takes the lowest free slot, then fill the table and overflow it
    add_row(OP_OPEN, 32'h55555555, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1, STS_OK, 16'd1);
    for (int k = 3; k < SLOTS; k++)
      add_row(OP_OPEN, 32'hA5A50000 + k, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1,
              STS_OK, 16'(k));
    add_row(OP_OPEN, 32'h0BADCAFE, BTN_SOUTH, 1'b0, AXIS_LX, 16'h0000, 1'b1, STS_NO_SLOT, 16'd0);

    // hold synchronous reset, then release it
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      typed = '0;
      typed.status    = directed_rows[k].status;
      typed.device_id = directed_rows[k].device_id;
      send_event(directed_rows[k].ev, directed_rows[k].typed, typed);
    end

    // random phases, each under its own first device id; the top value wraps
    write_first_id(16'hFFFF);
    random_phase(330, 1'b0);
    write_first_id(16'h0000);
    random_phase(330, 1'b1);
    write_first_id(16'($urandom));
    random_phase(330, 1'b0);
    write_first_id(16'hFFFC);
    quiet <= 1'b1;
    random_phase(330, 1'b0);

    drain_block();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
